/* rtl/core/assert_macros.svh */
// Assertion macros shared by the lattice chain growth RTL.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define ASSERT_IMPLIES(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);
// Next-cycle implication
`define ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, ant, cons, msg)
`define ASSERT_NEXT(lbl, ant, cons, msg)
`endif
`endif

/* rtl/core/plcg_pkg.sv */
// Shared types and constants of the lattice chain growth unit.
// No dependencies; imported by every module of the block.
package plcg_pkg;

  localparam int SIDE      = 32;
  localparam int MAX_BEADS = 1024;
  localparam int CW        = $clog2(SIDE);
  localparam int PW        = 3 * CW;
  localparam int SITES     = SIDE * SIDE * SIDE;
  localparam int CLW       = $clog2(MAX_BEADS);
  localparam int CNTW      = CLW + 1;
  localparam int EW        = CW + 1;
  localparam int PERS_W    = 17;
  localparam int RF_W      = 16;
  localparam int R5_W      = RF_W + 3;
  localparam int TRY_W     = 8;
  localparam int HD_W      = 3;

  // Request opcodes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_PERS  = 2'd0;
  localparam logic [1:0] REG_LEN   = 2'd1;
  localparam logic [1:0] REG_EDGE  = 2'd2;
  localparam logic [1:0] REG_TRIES = 2'd3;

  typedef enum logic [3:0] {
    ST_STARTED  = 4'd0,
    ST_OCCUPIED = 4'd1,
    ST_PLACED   = 4'd2,
    ST_BLOCKED  = 4'd3,
    ST_TRAPPED  = 4'd4,
    ST_TRIESOUT = 4'd5,
    ST_COMPLETE = 4'd6,
    ST_CLEARED  = 4'd7,
    ST_IGNORED  = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    K_CLEAR,
    K_START,
    K_STEP,
    K_IGNORE
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic [CW-1:0]   sx;
    logic [CW-1:0]   sy;
    logic [CW-1:0]   sz;
    logic [HD_W-1:0] start_hd;
    logic [R5_W-1:0] r5;
  } item_t;

  typedef struct packed {
    logic [PERS_W-1:0] pers;
    logic [CNTW-1:0]   len;
    logic [EW-1:0]     edge_len;
    logic [TRY_W-1:0]  mtries;
  } cfg_t;

endpackage

/* rtl/core/persistent_lattice_chain_growth_unit.sv */
// One request is in progress at a time; a two-entry queue keeps accepting meanwhile.
// The site map, with one read port (one read a cycle), sets the step time; trap, tries-out
// and commit walk the chain list bead by bead, and clear sweeps the whole site map.
// Reset (synchronous, rst_n low) clears control state, then a sweep over all 32768 sites
// empties the site map while no request is accepted.
`include "assert_macros.svh"
module persistent_lattice_chain_growth_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_op,
  input  logic [plcg_pkg::CW-1:0]   in_start_x,
  input  logic [plcg_pkg::CW-1:0]   in_start_y,
  input  logic [plcg_pkg::CW-1:0]   in_start_z,
  input  logic [15:0]               in_rand_frac,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [3:0]                out_status,
  output logic [plcg_pkg::CW-1:0]   out_bead_x,
  output logic [plcg_pkg::CW-1:0]   out_bead_y,
  output logic [plcg_pkg::CW-1:0]   out_bead_z,
  output logic [plcg_pkg::CNTW-1:0] out_beads_placed,
  output logic [plcg_pkg::HD_W-1:0] out_heading
);
  import plcg_pkg::*;

  logic [PERS_W-1:0] pers_r;
  logic [CNTW-1:0]   len_r;
  logic [EW-1:0]     edge_r;
  logic [TRY_W-1:0]  tries_r;
  cfg_t              cfg;
  logic              init_done;
  logic              q_valid;
  item_t             q_item;
  logic              q_pop;
  logic [1:0]        reg_idx;
  logic              out_dropped;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pers_r  <= PERS_W'(32768);
      len_r   <= CNTW'(16);
      edge_r  <= EW'(32);
      tries_r <= TRY_W'(200);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_PERS:  pers_r  <= pwdata[PERS_W-1:0];
        REG_LEN:   len_r   <= pwdata[CNTW-1:0];
        REG_EDGE:  edge_r  <= pwdata[EW-1:0];
        REG_TRIES: tries_r <= pwdata[TRY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      REG_PERS:  prdata = 32'(pers_r);
      REG_LEN:   prdata = 32'(len_r);
      REG_EDGE:  prdata = 32'(edge_r);
      REG_TRIES: prdata = 32'(tries_r);
      default:   prdata = '0;
    endcase
  end

  // Clamp the length, edge and tries registers to their working ranges
  always_comb begin
    cfg.pers = pers_r;
    if (len_r == '0) begin
      cfg.len = CNTW'(1);
    end else if (len_r > CNTW'(MAX_BEADS)) begin
      cfg.len = CNTW'(MAX_BEADS);
    end else begin
      cfg.len = len_r;
    end
    if (edge_r == '0) begin
      cfg.edge_len = EW'(1);
    end else if (edge_r > EW'(SIDE)) begin
      cfg.edge_len = EW'(SIDE);
    end else begin
      cfg.edge_len = edge_r;
    end
    cfg.mtries = (tries_r == '0) ? TRY_W'(1) : tries_r;
  end

  plcg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_start_x   (in_start_x),
    .in_start_y   (in_start_y),
    .in_start_z   (in_start_z),
    .in_rand_frac (in_rand_frac),
    .init_done    (init_done),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  plcg_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .init_done        (init_done),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_bead_x       (out_bead_x),
    .out_bead_y       (out_bead_y),
    .out_bead_z       (out_bead_z),
    .out_beads_placed (out_beads_placed),
    .out_heading      (out_heading)
  );

  assign out_dropped = out_valid && (out_status == ST_TRAPPED || out_status == ST_TRIESOUT);

  // No request enters before the site map sweep after reset is done
  `ASSERT_IMPLIES(a_no_accept_in_sweep, in_valid && in_ready, init_done, "request in sweep")
  // A trapped or tries-out result always reports an empty chain
  `ASSERT_IMPLIES(a_drop_empties, out_dropped, out_beads_placed == '0, "dropped chain not empty")
  // Bead count never exceeds the chain list depth
  `ASSERT_IMPLIES(a_count_bound, out_valid, out_beads_placed <= CNTW'(MAX_BEADS), "bead count overflow")
  // Once the sweep is done it stays done
  `ASSERT_NEXT(a_init_sticky, init_done, init_done, "init done dropped")

endmodule

/* rtl/core/plcg_front.sv */
// Front end: accepts requests, classifies them and queues them (two entries).
// Depends on plcg_pkg.
module plcg_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_op,
  input  logic [plcg_pkg::CW-1:0] in_start_x,
  input  logic [plcg_pkg::CW-1:0] in_start_y,
  input  logic [plcg_pkg::CW-1:0] in_start_z,
  input  logic [15:0]            in_rand_frac,
  input  logic                   init_done,
  output logic                   q_valid,
  output plcg_pkg::item_t        q_item,
  input  logic                   q_pop
);
  import plcg_pkg::*;

  item_t           fifo_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      cnt_r;
  item_t           new_item;
  logic [R5_W-1:0] r6;
  logic [R5_W-1:0] r6m1;
  logic            push;

  // Classify the request and precompute the start heading and 5r
  always_comb begin
    r6   = {3'b000, in_rand_frac} * R5_W'(6);
    r6m1 = r6 - R5_W'(1);
    new_item.sx = in_start_x;
    new_item.sy = in_start_y;
    new_item.sz = in_start_z;
    new_item.r5 = {3'b000, in_rand_frac} * R5_W'(5);
    new_item.start_hd = (in_rand_frac == '0) ? '0 : r6m1[R5_W-1:RF_W];
    unique case (in_op)
      OP_CLEAR: new_item.kind = K_CLEAR;
      OP_START: new_item.kind = K_START;
      OP_STEP:  new_item.kind = K_STEP;
      default:  new_item.kind = K_IGNORE;
    endcase
  end

  assign in_ready = init_done && (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = fifo_r[rd_ptr_r];

  // Store queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= new_item;
    end
  end

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

/* rtl/core/plcg_back.sv */
// Back end: sequencer over the site map and chain list memories, result register.
// Depends on plcg_pkg.
module plcg_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  plcg_pkg::cfg_t           cfg,
  input  logic                     q_valid,
  input  plcg_pkg::item_t          q_item,
  output logic                     q_pop,
  output logic                     init_done,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [3:0]               out_status,
  output logic [plcg_pkg::CW-1:0]  out_bead_x,
  output logic [plcg_pkg::CW-1:0]  out_bead_y,
  output logic [plcg_pkg::CW-1:0]  out_bead_z,
  output logic [plcg_pkg::CNTW-1:0] out_beads_placed,
  output logic [plcg_pkg::HD_W-1:0] out_heading
);
  import plcg_pkg::*;

  localparam logic [1:0] SM_EMPTY  = 2'd0;
  localparam logic [1:0] SM_COMMIT = 2'd1;
  localparam logic [1:0] SM_GROW   = 2'd2;
  localparam logic [2:0] LAST_NBR  = 3'd5;
  localparam logic [PERS_W-1:0] P_ONE = PERS_W'(65536);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SCHK, S_NBR, S_NLAST, S_DECIDE, S_WALK, S_OUT
  } state_t;

  // Memories
  logic [1:0]    site_mem  [SITES];
  logic [PW-1:0] chain_mem [MAX_BEADS];

  state_t           state_r;
  logic [PW-1:0]    clr_addr_r;
  logic             clr_res_r;
  logic             init_done_r;
  item_t            item_r;
  logic [PW-1:0]    head_r;
  logic [HD_W-1:0]  hd_r;
  logic [CNTW-1:0]  cnt_r;
  logic [TRY_W-1:0] try_r;
  logic             active_r;
  status_t          status_r;
  logic [2:0]       nidx_r;
  logic [2:0]       nidx_d_r;
  logic             npend_r;
  logic [5:0]       occ_r;
  logic [CNTW-1:0]  wk_i_r;
  logic             wk_pend_r;
  logic [1:0]       wk_val_r;
  logic             wk_drop_r;
  logic             out_valid_r;
  status_t          out_status_r;
  logic [PW-1:0]    out_pos_r;
  logic [CNTW-1:0]  out_cnt_r;
  logic [HD_W-1:0]  out_hd_r;

  logic [1:0]       sm_rdata_r;
  logic [PW-1:0]    cl_rdata_r;
  logic [PW-1:0]    sm_raddr;
  logic             sm_we;
  logic [PW-1:0]    sm_waddr;
  logic [1:0]       sm_wdata;
  logic             cl_we;
  logic [CLW-1:0]   cl_waddr;
  logic [PW-1:0]    cl_wdata;

  logic [PW-1:0]    q_pos;
  logic [PW-1:0]    item_pos;
  logic             q_outside;
  logic [TRY_W:0]   try_inc;
  logic [PW-1:0]    nb_addr;
  logic [PW-1:0]    t_addr;
  logic [HD_W-1:0]  pick;
  logic             all_full;
  logic             t_busy;
  logic [CNTW-1:0]  cnt_inc;
  logic             can_store;
  logic [R5_W+1:0]  r5w;
  logic [R5_W+1:0]  p5;
  logic [R5_W+1:0]  th1, th2, th3, th4;
  logic [R5_W+1:0]  pw;
  logic [HD_W-1:0]  alt;

  // Site one step from pos in direction dir, wrapped at edge e
  function automatic logic [PW-1:0] nbr(input logic [PW-1:0] pos,
                                        input logic [HD_W-1:0] dir,
                                        input logic [EW-1:0] e);
    logic [CW-1:0] c [3];
    logic [1:0]    ax;
    logic [EW-1:0] up;
    logic [CW-1:0] res;
    c[0] = pos[CW-1:0];
    c[1] = pos[2*CW-1:CW];
    c[2] = pos[3*CW-1:2*CW];
    ax   = dir[2:1];
    up   = {1'b0, c[ax]} + EW'(1);
    if (dir[0]) begin
      res = (c[ax] == '0) ? CW'(e - EW'(1)) : c[ax] - CW'(1);
    end else begin
      res = (up >= e) ? '0 : up[CW-1:0];
    end
    c[ax] = res;
    return {c[2], c[1], c[0]};
  endfunction

  assign q_pos     = {q_item.sz, q_item.sy, q_item.sx};
  assign item_pos  = {item_r.sz, item_r.sy, item_r.sx};
  assign q_outside = ({1'b0, q_item.sx} >= cfg.edge_len) ||
                     ({1'b0, q_item.sy} >= cfg.edge_len) ||
                     ({1'b0, q_item.sz} >= cfg.edge_len);
  assign try_inc   = {1'b0, try_r} + (TRY_W + 1)'(1);
  assign nb_addr   = nbr(head_r, nidx_r, cfg.edge_len);
  assign all_full  = &occ_r;
  assign t_addr    = nbr(head_r, pick, cfg.edge_len);
  assign t_busy    = occ_r[pick];
  assign can_store = (cnt_r < CNTW'(MAX_BEADS));
  assign cnt_inc   = can_store ? cnt_r + CNTW'(1) : cnt_r;
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign init_done = init_done_r;

  // Pick the direction: keep heading, else the first alternative under threshold (0 if that is the heading)
  always_comb begin
    pw  = (cfg.pers > P_ONE) ? (R5_W + 2)'(P_ONE) : (R5_W + 2)'(cfg.pers);
    r5w = (R5_W + 2)'(item_r.r5);
    p5  = (pw << 2) + pw;
    th1 = (pw << 2) + (R5_W + 2)'(65536);
    th2 = (pw << 1) + pw + (R5_W + 2)'(131072);
    th3 = (pw << 1) + (R5_W + 2)'(196608);
    th4 = pw + (R5_W + 2)'(262144);
    priority if (r5w <= th1) alt = 3'd2;
    else if (r5w <= th2)     alt = 3'd1;
    else if (r5w <= th3)     alt = 3'd3;
    else if (r5w <= th4)     alt = 3'd4;
    else                     alt = 3'd5;
    if (r5w <= p5) begin
      pick = hd_r;
    end else begin
      pick = (alt == hd_r) ? '0 : alt;
    end
  end

  // Route memory ports by state
  always_comb begin
    sm_raddr = (state_r == S_NBR) ? nb_addr : q_pos;
    sm_we    = 1'b0;
    sm_waddr = clr_addr_r;
    sm_wdata = SM_EMPTY;
    cl_we    = 1'b0;
    cl_waddr = cnt_r[CLW-1:0];
    cl_wdata = t_addr;
    unique case (state_r)
      S_CLR: begin
        sm_we = 1'b1;
      end
      S_WALK: begin
        sm_we    = wk_pend_r;
        sm_waddr = cl_rdata_r;
        sm_wdata = wk_val_r;
      end
      S_SCHK: begin
        sm_we    = (sm_rdata_r == SM_EMPTY);
        sm_waddr = item_pos;
        sm_wdata = SM_GROW;
        cl_we    = (sm_rdata_r == SM_EMPTY);
        cl_waddr = '0;
        cl_wdata = item_pos;
      end
      S_DECIDE: begin
        sm_we    = !all_full && !t_busy;
        sm_waddr = t_addr;
        sm_wdata = SM_GROW;
        cl_we    = !all_full && !t_busy && can_store;
      end
      default: begin
      end
    endcase
  end

  // Site map port
  always_ff @(posedge clk) begin
    if (sm_we) begin
      site_mem[sm_waddr] <= sm_wdata;
    end
    sm_rdata_r <= site_mem[sm_raddr];
  end

  // Chain list port
  always_ff @(posedge clk) begin
    if (cl_we) begin
      chain_mem[cl_waddr] <= cl_wdata;
    end
    cl_rdata_r <= chain_mem[wk_i_r[CLW-1:0]];
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      clr_res_r   <= 1'b0;
      init_done_r <= 1'b0;
      head_r      <= '0;
      hd_r        <= '0;
      cnt_r       <= '0;
      try_r       <= '0;
      active_r    <= 1'b0;
      status_r    <= ST_IGNORED;
      nidx_r      <= '0;
      nidx_d_r    <= '0;
      npend_r     <= 1'b0;
      wk_i_r      <= '0;
      wk_pend_r   <= 1'b0;
      wk_val_r    <= SM_EMPTY;
      wk_drop_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        // Sweep the whole site map to empty
        S_CLR: begin
          clr_addr_r <= clr_addr_r + PW'(1);
          if (clr_addr_r == PW'(SITES - 1)) begin
            init_done_r <= 1'b1;
            status_r    <= ST_CLEARED;
            state_r     <= clr_res_r ? S_OUT : S_IDLE;
          end
        end
        // Take the next request from the queue
        S_IDLE: begin
          if (q_valid) begin
            item_r   <= q_item;
            status_r <= ST_IGNORED;
            state_r  <= S_OUT;
            priority case (1'b1)
              q_item.kind == K_CLEAR: begin
                cnt_r      <= '0;
                try_r      <= '0;
                active_r   <= 1'b0;
                clr_addr_r <= '0;
                clr_res_r  <= 1'b1;
                state_r    <= S_CLR;
              end
              q_item.kind == K_START && !active_r: begin
                if (q_outside) begin
                  status_r <= ST_OCCUPIED;
                end else begin
                  state_r <= S_SCHK;
                end
              end
              q_item.kind == K_STEP && active_r: begin
                if (try_inc >= {1'b0, cfg.mtries}) begin
                  status_r  <= ST_TRIESOUT;
                  wk_i_r    <= '0;
                  wk_pend_r <= 1'b0;
                  wk_val_r  <= SM_EMPTY;
                  wk_drop_r <= 1'b1;
                  state_r   <= S_WALK;
                end else begin
                  try_r   <= try_inc[TRY_W-1:0];
                  nidx_r  <= '0;
                  npend_r <= 1'b0;
                  state_r <= S_NBR;
                end
              end
              default: begin
              end
            endcase
          end
        end
        // Check the start site and place the first bead
        S_SCHK: begin
          if (sm_rdata_r != SM_EMPTY) begin
            status_r <= ST_OCCUPIED;
            state_r  <= S_OUT;
          end else begin
            head_r   <= item_pos;
            cnt_r    <= CNTW'(1);
            try_r    <= '0;
            active_r <= 1'b1;
            hd_r     <= item_r.start_hd;
            if (cfg.len <= CNTW'(1)) begin
              status_r  <= ST_COMPLETE;
              active_r  <= 1'b0;
              wk_i_r    <= '0;
              wk_pend_r <= 1'b0;
              wk_val_r  <= SM_COMMIT;
              wk_drop_r <= 1'b0;
              state_r   <= S_WALK;
            end else begin
              status_r <= ST_STARTED;
              state_r  <= S_OUT;
            end
          end
        end
        // Read the six neighbours, one a cycle
        S_NBR: begin
          npend_r  <= 1'b1;
          nidx_d_r <= nidx_r;
          if (npend_r) begin
            occ_r[nidx_d_r] <= (sm_rdata_r != SM_EMPTY);
          end
          if (nidx_r == LAST_NBR) begin
            state_r <= S_NLAST;
          end else begin
            nidx_r <= nidx_r + 3'd1;
          end
        end
        S_NLAST: begin
          occ_r[nidx_d_r] <= (sm_rdata_r != SM_EMPTY);
          state_r         <= S_DECIDE;
        end
        // Trap check, direction draw and move
        S_DECIDE: begin
          if (all_full) begin
            status_r  <= ST_TRAPPED;
            wk_i_r    <= '0;
            wk_pend_r <= 1'b0;
            wk_val_r  <= SM_EMPTY;
            wk_drop_r <= 1'b1;
            state_r   <= S_WALK;
          end else begin
            hd_r <= pick;
            if (t_busy) begin
              status_r <= ST_BLOCKED;
              state_r  <= S_OUT;
            end else begin
              head_r <= t_addr;
              cnt_r  <= cnt_inc;
              try_r  <= '0;
              if (cnt_inc >= cfg.len) begin
                status_r  <= ST_COMPLETE;
                active_r  <= 1'b0;
                wk_i_r    <= '0;
                wk_pend_r <= 1'b0;
                wk_val_r  <= SM_COMMIT;
                wk_drop_r <= 1'b0;
                state_r   <= S_WALK;
              end else begin
                status_r <= ST_PLACED;
                state_r  <= S_OUT;
              end
            end
          end
        end
        // Walk the chain list, rewriting each bead site
        S_WALK: begin
          if (wk_i_r < cnt_r) begin
            wk_i_r    <= wk_i_r + CNTW'(1);
            wk_pend_r <= 1'b1;
          end else begin
            wk_pend_r <= 1'b0;
            if (!wk_pend_r) begin
              if (wk_drop_r) begin
                cnt_r <= '0;
              end
              try_r    <= '0;
              active_r <= 1'b0;
              state_r  <= S_OUT;
            end
          end
        end
        // Hand the result to the output register
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_pos_r    <= head_r;
            out_cnt_r    <= cnt_r;
            out_hd_r     <= hd_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_bead_x       = out_pos_r[CW-1:0];
  assign out_bead_y       = out_pos_r[2*CW-1:CW];
  assign out_bead_z       = out_pos_r[3*CW-1:2*CW];
  assign out_beads_placed = out_cnt_r;
  assign out_heading      = out_hd_r;

endmodule
